### src/deferred_task_queue_macros.svh
// ---------------------------------------------------------------------------
// Deferred task queue assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef DEFERRED_TASK_QUEUE_MACROS_SVH
`define DEFERRED_TASK_QUEUE_MACROS_SVH

// Same-cycle implication
`define DTQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/dtq_pkg.sv
// ---------------------------------------------------------------------------
// Deferred task queue package
// Sizes, operation and outcome codes, and the request/response records.
// ---------------------------------------------------------------------------
package dtq_pkg;

	// table size and index width
	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W     = $clog2(TASK_SLOTS);

	// field widths
	localparam int OP_W      = 3;
	localparam int ID_W      = 4;
	localparam int HANDLER_W = 8;
	localparam int DATA_W    = 32;
	localparam int OUTCOME_W = 2;

	// stream payload widths, padded to whole bytes
	localparam int IN_FIELDS_W  = ID_W + HANDLER_W + DATA_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = ID_W + HANDLER_W + DATA_W + 1;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_INIT     = 3'd0,
		OP_ENABLE   = 3'd1,
		OP_DISABLE  = 3'd2,
		OP_SCHEDULE = 3'd3,
		OP_DISPATCH = 3'd4,
		OP_COMPLETE = 3'd5
	} op_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_DONE   = 2'd0,
		OUT_REJECT = 2'd1,
		OUT_EMPTY  = 2'd2
	} outcome_t;

	// one accepted operation
	typedef struct packed {
		logic [OP_W-1:0]      operation;
		logic [ID_W-1:0]      task_id;
		logic [HANDLER_W-1:0] handler_number;
		logic [DATA_W-1:0]    data_word;
	} req_t;

	// one result
	typedef struct packed {
		outcome_t             outcome;
		logic [ID_W-1:0]      run_id;
		logic [HANDLER_W-1:0] run_handler;
		logic [DATA_W-1:0]    run_data;
		logic                 queue_empty;
	} rsp_t;

	// stage control between input register, core and result register
	typedef struct packed {
		logic advance;
	} pipe_ctl_t;

endpackage

### src/deferred_task_queue.sv
// ---------------------------------------------------------------------------
// Deferred task queue
// Task table with enable/queued/running marks and a FIFO of scheduled tasks.
// ---------------------------------------------------------------------------
// Takes one operation per clock while results are taken and returns exactly
// one result per operation, in order. An operation is registered on input;
// when it advances, it is applied to the task table and link registers and
// its result is registered for the master stream at the same edge, and the
// result register's occupancy sets when the next input can transfer. Tail and
// head registers keep every list change to a few link writes per operation.
// Handler and data of a task that was never initialized read as undefined.
module deferred_task_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dtq_pkg::IN_TDATA_W-1:0]  s_tdata,   // task_id, handler_number, data_word
	input  logic [dtq_pkg::OP_W-1:0]        s_tuser,   // operation
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dtq_pkg::OUT_TDATA_W-1:0] m_tdata,   // run_id, run_handler, run_data, queue_empty
	output logic [dtq_pkg::OUTCOME_W-1:0]   m_tuser    // outcome
);

	logic               space;
	logic               valid;
	dtq_pkg::req_t      req;
	dtq_pkg::rsp_t      rsp;
	dtq_pkg::pipe_ctl_t ctl;

	// item moves from input register to result register
	assign ctl.advance = valid && space;

	dtq_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.space    (space),
		.valid    (valid),
		.req      (req)
	);

	dtq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.rsp    (rsp)
	);

	dtq_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rsp      (rsp),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

### src/dtq_in_stage.sv
// ---------------------------------------------------------------------------
// Deferred task queue input stage
// Registers one operation from the slave stream and holds it until the core
// moves it into the result register.
// ---------------------------------------------------------------------------
module dtq_in_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [dtq_pkg::IN_TDATA_W-1:0] s_tdata,   // task_id, handler_number, data_word
	input  logic [dtq_pkg::OP_W-1:0]       s_tuser,   // operation
	input  logic                           space,
	output logic                           valid,
	output dtq_pkg::req_t                  req
);

	logic          valid_s1;
	dtq_pkg::req_t req_s1;
	logic          take;

	// slot is free when empty or when its item moves on this cycle
	assign s_tready = !valid_s1 || space;
	assign take     = s_tvalid && s_tready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (space) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (take) begin
			req_s1.operation      <= s_tuser;
			req_s1.task_id        <= s_tdata[dtq_pkg::ID_W-1:0];
			req_s1.handler_number <= s_tdata[dtq_pkg::ID_W +: dtq_pkg::HANDLER_W];
			req_s1.data_word      <= s_tdata[dtq_pkg::ID_W + dtq_pkg::HANDLER_W +: dtq_pkg::DATA_W];
		end
	end

	assign valid = valid_s1;
	assign req   = req_s1;

endmodule

### src/dtq_core.sv
// ---------------------------------------------------------------------------
// Deferred task queue core
// Task marks, handler and data tables and the doubly linked FIFO; applies one
// operation per advance and forms its result.
// ---------------------------------------------------------------------------
`include "deferred_task_queue_macros.svh"

module dtq_core (
	input  logic               clk,
	input  logic               arst_n,
	input  dtq_pkg::pipe_ctl_t ctl,
	input  dtq_pkg::req_t      req,
	output dtq_pkg::rsp_t      rsp
);

	localparam int N = dtq_pkg::TASK_SLOTS;
	localparam int W = dtq_pkg::SLOT_W;

	// marks and list registers
	logic [N-1:0] enabled_q, queued_q, running_q;
	logic [W-1:0] head_q, tail_q;
	logic         nonempty_q;
	logic [W-1:0] fwd_q [N];
	logic [W-1:0] bwd_q [N];
	logic [dtq_pkg::HANDLER_W-1:0] handler_q [N];
	logic [dtq_pkg::DATA_W-1:0]    data_q    [N];

	// next state
	logic [N-1:0] enabled_d, queued_d, running_d;
	logic [W-1:0] head_d, tail_d;
	logic         nonempty_d;
	logic [W-1:0] fwd_d [N];
	logic [W-1:0] bwd_d [N];

	logic          id_ok;
	logic [W-1:0]  t;
	logic          do_unlink, do_append, do_store;
	logic [W-1:0]  x, nx, px;
	logic          is_head, is_tail;
	dtq_pkg::rsp_t rsp_d;

	assign id_ok = (32'(req.task_id) < 32'(N));
	assign t     = id_ok ? W'(req.task_id) : '0;

	// operation decode, marks and result
	always_comb begin
		enabled_d = enabled_q;
		running_d = running_q;
		do_unlink = 1'b0;
		do_append = 1'b0;
		do_store  = 1'b0;
		x         = t;
		rsp_d     = '0;
		rsp_d.outcome = dtq_pkg::OUT_DONE;
		unique case (req.operation)
			dtq_pkg::OP_INIT: begin
				if (!id_ok || req.handler_number == '0) begin
					rsp_d.outcome = dtq_pkg::OUT_REJECT;
				end else begin
					do_unlink    = queued_q[t];
					do_store     = 1'b1;
					enabled_d[t] = 1'b0;
					running_d[t] = 1'b0;
				end
			end
			dtq_pkg::OP_ENABLE: begin
				if (id_ok) enabled_d[t] = 1'b1;
			end
			dtq_pkg::OP_DISABLE: begin
				if (id_ok) begin
					do_unlink    = queued_q[t];
					enabled_d[t] = 1'b0;
					running_d[t] = 1'b0;
				end
			end
			dtq_pkg::OP_SCHEDULE: begin
				do_append = id_ok && enabled_q[t] && !queued_q[t];
			end
			dtq_pkg::OP_DISPATCH: begin
				if (!nonempty_q) begin
					rsp_d.outcome = dtq_pkg::OUT_EMPTY;
				end else begin
					x                 = head_q;
					do_unlink         = 1'b1;
					running_d[head_q] = 1'b1;
					rsp_d.run_id      = dtq_pkg::ID_W'(head_q);
					rsp_d.run_handler = handler_q[head_q];
					rsp_d.run_data    = data_q[head_q];
				end
			end
			dtq_pkg::OP_COMPLETE: begin
				if (id_ok) running_d[t] = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// list neighbors of the task being removed
	assign nx      = fwd_q[x];
	assign px      = bwd_q[x];
	assign is_head = (x == head_q);
	assign is_tail = (x == tail_q);

	// link updates: unlink from anywhere, or append at the tail
	always_comb begin
		fwd_d      = fwd_q;
		bwd_d      = bwd_q;
		queued_d   = queued_q;
		head_d     = head_q;
		tail_d     = tail_q;
		nonempty_d = nonempty_q;
		if (do_unlink) begin
			if (is_head && is_tail) begin
				nonempty_d = 1'b0;
				head_d     = '0;
				tail_d     = '0;
			end else begin
				if (is_head) begin
					head_d    = nx;
					bwd_d[nx] = '0;
				end else begin
					fwd_d[px] = nx;
				end
				if (is_tail) begin
					tail_d    = px;
					fwd_d[px] = '0;
				end else if (!is_head) begin
					bwd_d[nx] = px;
				end
			end
			fwd_d[x]    = '0;
			bwd_d[x]    = '0;
			queued_d[x] = 1'b0;
		end else if (do_append) begin
			fwd_d[t] = '0;
			if (!nonempty_q) begin
				head_d     = t;
				tail_d     = t;
				bwd_d[t]   = '0;
				nonempty_d = 1'b1;
			end else begin
				fwd_d[tail_q] = t;
				bwd_d[t]      = tail_q;
				tail_d        = t;
			end
			queued_d[t] = 1'b1;
		end
	end

	// result with the queue state after the operation
	always_comb begin
		rsp             = rsp_d;
		rsp.queue_empty = !nonempty_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= '0;
			queued_q   <= '0;
			running_q  <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			nonempty_q <= 1'b0;
		end else if (ctl.advance) begin
			enabled_q  <= enabled_d;
			queued_q   <= queued_d;
			running_q  <= running_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			nonempty_q <= nonempty_d;
		end
	end

	// links and task tables, undefined until written
	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			fwd_q <= fwd_d;
			bwd_q <= bwd_d;
			if (do_store) begin
				handler_q[t] <= req.handler_number;
				data_q[t]    <= req.data_word;
			end
		end
	end

	`DTQ_ASSERT_NOW(a_empty_none_queued, !nonempty_q, queued_q == '0, "queue empty but a task is queued")
	`DTQ_ASSERT_NOW(a_ends_queued, nonempty_q, queued_q[head_q] && queued_q[tail_q], "head or tail not queued")
	`DTQ_ASSERT_NOW(a_queued_enabled, 1'b1, (queued_q & ~enabled_q) == '0, "queued task not enabled")
	`DTQ_ASSERT_NEXT(a_dispatch_runs, ctl.advance && req.operation == dtq_pkg::OP_DISPATCH && nonempty_q, running_q[$past(head_q)] && !queued_q[$past(head_q)], "dispatched task not marked running")

endmodule

### src/dtq_out_stage.sv
// ---------------------------------------------------------------------------
// Deferred task queue result register
// Holds one result on the master stream until it is taken.
// ---------------------------------------------------------------------------
module dtq_out_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dtq_pkg::pipe_ctl_t              ctl,
	input  dtq_pkg::rsp_t                   rsp,
	output logic                            space,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dtq_pkg::OUT_TDATA_W-1:0] m_tdata,  // run_id, run_handler, run_data, queue_empty
	output logic [dtq_pkg::OUTCOME_W-1:0]   m_tuser   // outcome
);

	logic          valid_q;
	dtq_pkg::rsp_t rsp_q;

	// free when empty or when the held result transfers now
	assign space = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.advance) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			rsp_q <= rsp;
		end
	end

	// pack fields, lowest first
	assign m_tvalid = valid_q;
	assign m_tuser  = rsp_q.outcome;
	assign m_tdata  = dtq_pkg::OUT_TDATA_W'({rsp_q.queue_empty, rsp_q.run_data,
		rsp_q.run_handler, rsp_q.run_id});

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Deferred task queue testbench
// Drives init, enable, disable, schedule, dispatch, complete and reserved
// operations over the slave stream, with random gaps on both handshakes.
// Every result is checked field by field against an in-order prediction from
// a behavioral copy of the task table and its scheduled-task FIFO, or a fixed row.
// ---------------------------------------------------------------------------
module tb_top;
	import dtq_pkg::*;

	localparam int RANDOM_OPS  = 1125;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 10;
	localparam int REPORT_MAX  = 10;

	// codes outside the defined operation set
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	// result payload bit positions
	localparam int RUN_ID_LO  = 0;
	localparam int RUN_H_LO   = RUN_ID_LO + ID_W;
	localparam int RUN_D_LO   = RUN_H_LO + HANDLER_W;
	localparam int QEMPTY_BIT = RUN_D_LO + DATA_W;

	// stimulus phases for the random part
	typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

	// one row of the directed table
	typedef struct {
		logic [OP_W-1:0]      op;
		logic [ID_W-1:0]      id;
		logic [HANDLER_W-1:0] handler;
		logic [DATA_W-1:0]    data;
		bit                   fixed;
		rsp_t                 result;
	} stim_row_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic [OP_W-1:0]        s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUTCOME_W-1:0]   m_tuser;

	// behavioral copy of the block's state
	bit                   task_enabled [TASK_SLOTS];
	bit                   task_queued  [TASK_SLOTS];
	bit                   task_running [TASK_SLOTS];
	logic [ID_W-1:0]      next_link    [TASK_SLOTS];
	logic [ID_W-1:0]      prev_link    [TASK_SLOTS];
	logic [HANDLER_W-1:0] handler_mem  [TASK_SLOTS];
	logic [DATA_W-1:0]    data_mem     [TASK_SLOTS];
	logic [ID_W-1:0]      fifo_head;
	logic [ID_W-1:0]      fifo_tail;
	bit                   fifo_busy;
	int                   fifo_depth;
	int                   fifo_depth_max;

	// what the stimulus side has issued so far, to keep uninitialized tasks
	// from ever being scheduled
	bit ever_init [TASK_SLOTS];
	bit issued_en [TASK_SLOTS];

	rsp_t      pending_q [$];
	stim_row_t directed  [$];

	bit   row_fixed;
	rsp_t row_result;
	bit   no_idle;
	int   idle_run;
	int   mismatches;
	int   checked;
	int   dispatched;
	int   empty_pops;
	int   issued;

	deferred_task_queue i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// take a queued task out of the FIFO wherever it sits
	function automatic void fifo_unlink(input logic [ID_W-1:0] x);
		logic [ID_W-1:0] nx;
		logic [ID_W-1:0] px;
		bit              at_head;
		bit              at_tail;
		nx      = next_link[x];
		px      = prev_link[x];
		at_head = (x == fifo_head);
		at_tail = (x == fifo_tail);
		if (at_head && at_tail) begin
			fifo_busy = 1'b0;
			fifo_head = '0;
			fifo_tail = '0;
		end else begin
			if (at_head) begin
				fifo_head     = nx;
				prev_link[nx] = '0;
			end else begin
				next_link[px] = nx;
			end
			if (at_tail) begin
				fifo_tail     = px;
				next_link[px] = '0;
			end else if (!at_head) begin
				prev_link[nx] = px;
			end
		end
		next_link[x]   = '0;
		prev_link[x]   = '0;
		task_queued[x] = 1'b0;
		fifo_depth--;
	endfunction

	function automatic void fifo_append(input logic [ID_W-1:0] x);
		next_link[x] = '0;
		if (!fifo_busy) begin
			fifo_head    = x;
			fifo_tail    = x;
			prev_link[x] = '0;
			fifo_busy    = 1'b1;
		end else begin
			next_link[fifo_tail] = x;
			prev_link[x]         = fifo_tail;
			fifo_tail            = x;
		end
		task_queued[x] = 1'b1;
		fifo_depth++;
		if (fifo_depth > fifo_depth_max)
			fifo_depth_max = fifo_depth;
	endfunction

	// apply one operation to the task table, return the expected result
	function automatic rsp_t run_task_op(input logic [OP_W-1:0] op,
			input logic [ID_W-1:0] id, input logic [HANDLER_W-1:0] handler,
			input logic [DATA_W-1:0] data);
		rsp_t            r;
		logic [ID_W-1:0] h;
		r = '{outcome: OUT_DONE, run_id: '0, run_handler: '0, run_data: '0,
			queue_empty: 1'b0};
		case (op)
			OP_INIT: begin
				if (handler == '0) begin
					r.outcome = OUT_REJECT;
				end else begin
					if (task_queued[id])
						fifo_unlink(id);
					task_enabled[id] = 1'b0;
					task_running[id] = 1'b0;
					handler_mem[id]  = handler;
					data_mem[id]     = data;
				end
			end
			OP_ENABLE: begin
				task_enabled[id] = 1'b1;
			end
			OP_DISABLE: begin
				if (task_queued[id])
					fifo_unlink(id);
				task_enabled[id] = 1'b0;
				task_running[id] = 1'b0;
			end
			OP_SCHEDULE: begin
				if (task_enabled[id] && !task_queued[id])
					fifo_append(id);
			end
			OP_DISPATCH: begin
				if (!fifo_busy) begin
					r.outcome = OUT_EMPTY;
				end else begin
					h = fifo_head;
					fifo_unlink(h);
					task_running[h] = 1'b1;
					r.run_id      = h;
					r.run_handler = handler_mem[h];
					r.run_data    = data_mem[h];
				end
			end
			OP_COMPLETE: begin
				task_running[id] = 1'b0;
			end
			default: begin
				// reserved codes leave everything alone
			end
		endcase
		r.queue_empty = !fifo_busy;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic rsp_t mk_rsp(input outcome_t oc, input logic [ID_W-1:0] id,
			input logic [HANDLER_W-1:0] h, input logic [DATA_W-1:0] d, input logic qe);
		rsp_t r;
		r = '{outcome: oc, run_id: id, run_handler: h, run_data: d, queue_empty: qe};
		return r;
	endfunction

	function automatic void add_row(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [HANDLER_W-1:0] h, input logic [DATA_W-1:0] d);
		stim_row_t s;
		s = '{op: op, id: id, handler: h, data: d, fixed: 1'b0, result: '0};
		directed.push_back(s);
	endfunction

	function automatic void add_fixed(input logic [OP_W-1:0] op,
			input logic [ID_W-1:0] id, input logic [HANDLER_W-1:0] h,
			input logic [DATA_W-1:0] d, input rsp_t res);
		stim_row_t s;
		s = '{op: op, id: id, handler: h, data: d, fixed: 1'b1, result: res};
		directed.push_back(s);
	endfunction

	// present one operation and hold it until the transfer
	task automatic send_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [HANDLER_W-1:0] h, input logic [DATA_W-1:0] d,
			input bit fixed, input rsp_t res);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			s_tdata  = IN_TDATA_W'({$urandom, $urandom});
			s_tuser  = OP_W'($urandom);
		end
		@(negedge clk);
		s_tdata    = {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, d, h, id};
		s_tuser    = op;
		row_fixed  = fixed;
		row_result = res;
		s_tvalid   = 1'b1;
		do @(posedge clk); while (!s_tready);
		// track what has been issued
		if (op == OP_INIT && h != '0) begin
			ever_init[id] = 1'b1;
			issued_en[id] = 1'b0;
		end else if (op == OP_ENABLE) begin
			issued_en[id] = 1'b1;
		end else if (op == OP_DISABLE) begin
			issued_en[id] = 1'b0;
		end
		issued++;
	endtask

	// one random operation, weighted by phase
	task automatic make_random_op(input phase_t ph, output logic [OP_W-1:0] op,
			output logic [ID_W-1:0] id, output logic [HANDLER_W-1:0] h,
			output logic [DATA_W-1:0] d);
		int w [7];
		int r;
		int acc;
		int k;
		logic [OP_W-1:0] codes [7];
		codes = '{OP_INIT, OP_ENABLE, OP_SCHEDULE, OP_DISPATCH, OP_DISABLE,
			OP_COMPLETE, OP_RSVD6};
		case (ph)
			PH_FILL:  w = '{15, 25, 40, 8, 4, 5, 3};
			PH_DRAIN: w = '{8, 10, 12, 50, 8, 10, 2};
			default:  w = '{15, 20, 25, 20, 8, 8, 4};
		endcase
		r   = $urandom_range(0, 99);
		acc = 0;
		op  = OP_RSVD7;
		for (k = 0; k < 7; k++) begin
			acc += w[k];
			if (r < acc) begin
				op = codes[k];
				break;
			end
		end
		if (op == OP_RSVD6 && $urandom_range(0, 1))
			op = OP_RSVD7;
		// a small pool of tasks most of the time, so operations collide
		if ($urandom_range(0, 2) == 0)
			id = ID_W'($urandom_range(0, TASK_SLOTS - 1));
		else
			id = ID_W'($urandom_range(0, 5));
		r = $urandom_range(0, 19);
		if (r == 0)
			h = '0;
		else if (r == 1)
			h = '1;
		else if (r == 2)
			h = 8'd1;
		else
			h = HANDLER_W'($urandom_range(1, 255));
		r = $urandom_range(0, 19);
		if (r == 0)
			d = '0;
		else if (r == 1)
			d = '1;
		else
			d = $urandom;
		// an enabled task that never got a handler must not reach the FIFO
		if (op == OP_SCHEDULE && issued_en[id] && !ever_init[id]) begin
			op = OP_INIT;
			if (h == '0)
				h = 8'd1;
		end
	endtask

	// ---------------------------------------------------------------------
	// Monitor: predict on input transfer, check on output transfer
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		rsp_t want;
		rsp_t got;
		bit   bad;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = run_task_op(s_tuser, s_tdata[ID_W-1:0],
					s_tdata[ID_W +: HANDLER_W], s_tdata[ID_W + HANDLER_W +: DATA_W]);
				if (row_fixed)
					want = row_result;
				pending_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.outcome     = outcome_t'(m_tuser);
				got.run_id      = m_tdata[RUN_ID_LO +: ID_W];
				got.run_handler = m_tdata[RUN_H_LO +: HANDLER_W];
				got.run_data    = m_tdata[RUN_D_LO +: DATA_W];
				got.queue_empty = m_tdata[QEMPTY_BIT];
				if (pending_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: result transfer with nothing pending: oc=%0d id=%0d",
							$realtime, got.outcome, got.run_id);
				end else begin
					want = pending_q.pop_front();
					checked++;
					if (want.outcome == OUT_EMPTY)
						empty_pops++;
					else if (want.run_handler != '0)
						dispatched++;
					bad = (got.outcome !== want.outcome) || (got.run_id !== want.run_id) ||
						(got.run_handler !== want.run_handler) ||
						(got.run_data !== want.run_data) ||
						(got.queue_empty !== want.queue_empty);
					if (bad) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display({"%0t: result %0d mismatch: outcome %0d/%0d id %0d/%0d ",
								"handler %h/%h data %h/%h empty %b/%b (exp/got)"},
								$realtime, checked, want.outcome, got.outcome,
								want.run_id, got.run_id, want.run_handler,
								got.run_handler, want.run_data, got.run_data,
								want.queue_empty, got.queue_empty);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_run <= 0;
			else
				idle_run <= idle_run + 1;
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		while (idle_run < STALL_LIMIT)
			@(posedge clk);
		$display("watchdog: no transfer for %0d cycles, %0d results pending",
			STALL_LIMIT, pending_q.size());
		$display("status: fail");
		$finish;
	end

	// result side back-pressure
	initial begin : sink_ready
		int stall;
		int burst;
		@(posedge arst_n);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				@(negedge clk);
				m_tready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready = 1'b1;
			burst = $urandom_range(1, 12);
			repeat (burst - 1) @(negedge clk);
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin : main
		logic [OP_W-1:0]      op;
		logic [ID_W-1:0]      id;
		logic [HANDLER_W-1:0] h;
		logic [DATA_W-1:0]    d;
		phase_t               ph;
		int                   n;
		int                   k;

		for (k = 0; k < TASK_SLOTS; k++) begin
			task_enabled[k] = 1'b0;
			task_queued[k]  = 1'b0;
			task_running[k] = 1'b0;
			next_link[k]    = '0;
			prev_link[k]    = '0;
			handler_mem[k]  = '0;
			data_mem[k]     = '0;
			ever_init[k]    = 1'b0;
			issued_en[k]    = 1'b0;
		end
		fifo_head      = '0;
		fifo_tail      = '0;
		fifo_busy      = 1'b0;
		fifo_depth     = 0;
		fifo_depth_max = 0;
		row_fixed      = 1'b0;
		row_result     = '0;
		no_idle        = 1'b0;
		idle_run       = 0;
		mismatches     = 0;
		checked        = 0;
		dispatched     = 0;
		empty_pops     = 0;
		issued         = 0;

		// directed table
		add_fixed(OP_DISPATCH, 4'd0, 8'h00, 32'h0, mk_rsp(OUT_EMPTY, 0, 0, 0, 1'b1));
		add_fixed(OP_INIT, 4'd0, 8'h00, 32'hdeadbeef, mk_rsp(OUT_REJECT, 0, 0, 0, 1'b1));
		add_fixed(OP_COMPLETE, 4'd9, 8'h00, 32'h0, mk_rsp(OUT_DONE, 0, 0, 0, 1'b1));
		add_fixed(OP_INIT, 4'd15, 8'hff, 32'hffffffff, mk_rsp(OUT_DONE, 0, 0, 0, 1'b1));
		add_fixed(OP_INIT, 4'd0, 8'h01, 32'h0, mk_rsp(OUT_DONE, 0, 0, 0, 1'b1));
		// schedule of a disabled task does nothing
		add_fixed(OP_SCHEDULE, 4'd0, 8'h00, 32'h0, mk_rsp(OUT_DONE, 0, 0, 0, 1'b1));
		add_row(OP_ENABLE, 4'd15, 8'h00, 32'h0);
		add_row(OP_ENABLE, 4'd15, 8'h00, 32'h0);
		add_row(OP_ENABLE, 4'd0, 8'h00, 32'h0);
		add_row(OP_SCHEDULE, 4'd15, 8'h00, 32'h0);
		add_row(OP_SCHEDULE, 4'd15, 8'h00, 32'h0);
		add_row(OP_SCHEDULE, 4'd0, 8'h00, 32'h0);
		add_row(OP_INIT, 4'd5, 8'h80, 32'h80000000);
		add_row(OP_ENABLE, 4'd5, 8'h00, 32'h0);
		add_row(OP_SCHEDULE, 4'd5, 8'h00, 32'h0);
		add_row(OP_DISPATCH, 4'd3, 8'h00, 32'h0);
		// dispatched task stays enabled, so it can be queued again
		add_row(OP_SCHEDULE, 4'd15, 8'h00, 32'h0);
		add_row(OP_DISABLE, 4'd5, 8'h00, 32'h0);
		// init of a queued tail task unlinks it and clears running
		add_row(OP_INIT, 4'd15, 8'h7f, 32'h12345678);
		add_row(OP_DISABLE, 4'd7, 8'h00, 32'h0);
		add_row(OP_DISPATCH, 4'd0, 8'h00, 32'h0);
		add_row(OP_COMPLETE, 4'd0, 8'h00, 32'h0);
		add_fixed(OP_DISPATCH, 4'd12, 8'h00, 32'h0, mk_rsp(OUT_EMPTY, 0, 0, 0, 1'b1));
		add_row(OP_RSVD6, 4'd1, 8'h55, 32'h5555aaaa);
		add_row(OP_RSVD7, 4'd14, 8'haa, 32'haaaa5555);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_op(directed[i].op, directed[i].id, directed[i].handler,
				directed[i].data, directed[i].fixed, directed[i].result);

		// random part: fill, drain and mixed phases, some stretches without gaps
		ph = PH_FILL;
		for (n = 0; n < RANDOM_OPS; n++) begin
			if (n % 60 == 0)
				ph = phase_t'($urandom_range(0, 2));
			no_idle = ((n % 200) >= 160);
			make_random_op(ph, op, id, h, d);
			send_op(op, id, h, d, 1'b0, '0);
		end
		no_idle = 1'b0;

		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
		if (pending_q.size() != 0)
			mismatches++;

		$display("ran %0d operations (%0d from the table), %0d results checked",
			issued, directed.size(), checked);
		$display("%0d tasks dispatched, %0d dispatches found the queue empty, deepest queue %0d",
			dispatched, empty_pops, fifo_depth_max);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule

### files.f
+incdir+src
src/dtq_pkg.sv
src/dtq_in_stage.sv
src/dtq_core.sv
src/dtq_out_stage.sv
src/deferred_task_queue.sv
test/tb_top.sv
